// File: rtl/ccq_pkg.sv
// Package with shared types, constants and classification functions for the command queue.
`default_nettype none
package ccq_pkg;
   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [4:0] T_NOTE_ON = 5'd0;
   localparam logic [4:0] T_NOTE_OFF = 5'd1;
   localparam logic [4:0] T_CC = 5'd3;
   localparam logic [4:0] T_ALL_OFF = 5'd4;
   localparam logic [4:0] T_PANIC = 5'd5;
   localparam logic [4:0] T_MESSAGE = 5'd11;

   localparam logic [15:0] CC_SUSTAIN = 16'd64;
   localparam logic [15:0] CC_SOUND_OFF = 16'd120;
   localparam logic [15:0] CC_NOTES_OFF = 16'd123;
   localparam logic signed [15:0] SUSTAIN_LIMIT = 16'sd64;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_TAKE = 2'd1;
   localparam logic [1:0] ACT_ACK = 2'd2;

   localparam logic [3:0] ST_QUEUED = 4'd0;
   localparam logic [3:0] ST_COALESCED = 4'd1;
   localparam logic [3:0] ST_DROPPED = 4'd2;
   localparam logic [3:0] ST_DROP_PANIC = 4'd3;
   localparam logic [3:0] ST_PANIC_RAISED = 4'd4;
   localparam logic [3:0] ST_DELIVERED = 4'd5;
   localparam logic [3:0] ST_PANIC_DELIV = 4'd6;
   localparam logic [3:0] ST_STALE = 4'd7;
   localparam logic [3:0] ST_EMPTY = 4'd8;
   localparam logic [3:0] ST_ACKED = 4'd9;

   typedef struct packed {
      logic [4:0] cmd_type;
      logic [7:0] channel;
      logic [15:0] id;
      logic [15:0] first_value;
      logic [31:0] payload;
      logic [31:0] generation;
      logic [31:0] timestamp;
   } entry_type;

   typedef struct packed {
      logic [4:0] cmd_type;
      logic [7:0] channel;
      logic [15:0] id;
   } key_type;

   function automatic logic coalescible_kind(input logic [4:0] t);
      case (t)
         5'd2, 5'd3, 5'd6, 5'd12, 5'd13, 5'd14, 5'd16, 5'd17, 5'd18, 5'd20, 5'd21,
         5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic is_release(input logic [4:0] t, input logic [15:0] id,
                                       input logic [15:0] v);
      logic signed [15:0] sv;
      sv = v;
      if (t == T_NOTE_OFF || t == T_ALL_OFF) return 1'b1;
      if (t == T_NOTE_ON && v == 16'd0) return 1'b1;
      if (t == T_CC && ((id == CC_SUSTAIN && sv < SUSTAIN_LIMIT) || id == CC_SOUND_OFF
                        || id == CC_NOTES_OFF)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic is_musical(input logic [4:0] t);
      return (t <= T_ALL_OFF) || (t == T_MESSAGE);
   endfunction
endpackage
`default_nettype wire

// File: rtl/ccq_cell.sv
// One queue cell: holds an entry, shifts toward the head on a pop, and loads or updates it in place.
`default_nettype none
module ccq_cell (
   input  wire logic clock,
   input  wire ccq_pkg::entry_type from_next,
   input  wire logic shift,
   input  wire logic load,
   input  wire logic update,
   input  wire ccq_pkg::entry_type new_entry,
   input  wire ccq_pkg::key_type probe,
   output ccq_pkg::entry_type entry,
   output logic hit
);
   import ccq_pkg::*;
   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = from_next;
      end else if (load) begin
         entry_in = new_entry;
      end else if (update) begin
         entry_in.first_value = new_entry.first_value;
         entry_in.payload = new_entry.payload;
         entry_in.timestamp = new_entry.timestamp;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign hit = (entry_ff.cmd_type == probe.cmd_type) && (entry_ff.channel == probe.channel)
                && (entry_ff.id == probe.id);
endmodule
`default_nettype wire

// File: rtl/coalescing_command_queue_unit.sv
// Top level of the coalescing command queue: control, cell row and register port.
`default_nettype none
// Entries sit in a row of cells with the oldest at cell 0; a take shifts the row
// by one cell. An enqueue of a continuous type scans the pending entries one cell
// per cycle from newest to oldest and then goes to the execute state; every other
// command goes straight to the execute state. Busy stays high from the accepted
// command until the execute state ends, and the result is registered from that state.
// The result appears for one cycle on rsp_valid, which the receiver cannot stall.
module coalescing_command_queue_unit (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [1:0] req_action,
   input  wire logic [4:0] req_cmd_type,
   input  wire logic [7:0] req_channel,
   input  wire logic [15:0] req_id,
   input  wire logic signed [15:0] req_first_value,
   input  wire logic [31:0] req_payload,
   input  wire logic [31:0] req_timestamp,
   output logic rsp_valid,
   output logic [3:0] rsp_status,
   output logic [4:0] rsp_out_type,
   output logic [7:0] rsp_out_channel,
   output logic [15:0] rsp_out_id,
   output logic signed [15:0] rsp_out_first_value,
   output logic [31:0] rsp_out_payload,
   output logic [31:0] rsp_out_generation,
   output logic [31:0] rsp_out_timestamp,
   output logic [5:0] rsp_queue_count,
   output logic rsp_recovery_pending,
   output logic [5:0] rsp_high_water,
   output logic [31:0] rsp_dropped_total,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import ccq_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_type;

   state_type state_ff;
   logic [1:0] act_ff;
   entry_type cmd_ff;
   logic [CNT_W-1:0] count_ff, peak_ff, scan_ff;
   logic [31:0] req_gen_ff, app_gen_ff, panic_time_ff, drops_ff;
   logic recovery_ff, found_ff;
   logic [IDX_W-1:0] found_idx_ff;
   logic [4:0] reserve_ff;

   entry_type cells [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] hits, shift_v, load_v, upd_v;
   key_type probe;
   entry_type new_entry;

   logic do_shift, do_load, do_update;
   logic [IDX_W-1:0] scan_idx;

   logic [3:0] status_in;
   entry_type deliver_in;
   logic [CNT_W-1:0] count_in, peak_in;
   logic [31:0] req_gen_in, app_gen_in, panic_time_in, drops_in;
   logic recovery_in, rec_pend_in;

   assign probe = '{cmd_type: cmd_ff.cmd_type, channel: cmd_ff.channel, id: cmd_ff.id};
   assign new_entry = '{cmd_type: cmd_ff.cmd_type, channel: cmd_ff.channel, id: cmd_ff.id,
                        first_value: cmd_ff.first_value, payload: cmd_ff.payload,
                        generation: req_gen_ff, timestamp: cmd_ff.timestamp};
   assign scan_idx = scan_ff[IDX_W-1:0];

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_type nxt;
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign nxt = cells[g];
      end else begin : g_mid
         assign nxt = cells[g+1];
      end
      assign shift_v[g] = do_shift;
      assign load_v[g] = do_load && (count_ff[IDX_W-1:0] == IDX_W'(g));
      assign upd_v[g] = do_update && (found_idx_ff == IDX_W'(g));
      ccq_cell u_cell (
         .clock(clock), .from_next(nxt), .shift(shift_v[g]), .load(load_v[g]),
         .update(upd_v[g]), .new_entry(new_entry), .probe(probe),
         .entry(cells[g]), .hit(hits[g])
      );
   end

   logic rel, no_room;
   logic [CNT_W-1:0] limit;
   entry_type head;
   assign rel = is_release(cmd_ff.cmd_type, cmd_ff.id, cmd_ff.first_value);
   assign limit = rel ? CNT_W'(QUEUE_DEPTH) :
                  ({1'b0, reserve_ff} >= 6'(QUEUE_DEPTH)) ? '0 :
                  CNT_W'(QUEUE_DEPTH - int'(reserve_ff));
   assign no_room = count_ff >= limit;
   assign head = cells[0];

   always_comb begin
      do_shift = 1'b0;
      do_load = 1'b0;
      do_update = 1'b0;
      if (state_ff == S_EXEC) begin
         if (act_ff == ACT_TAKE && app_gen_ff == req_gen_ff && count_ff != '0)
            do_shift = 1'b1;
         if (act_ff == ACT_ENQUEUE && cmd_ff.cmd_type != T_PANIC) begin
            if (found_ff) do_update = 1'b1;
            else if (!no_room) do_load = 1'b1;
         end
      end
   end

   always_comb begin
      status_in = ST_EMPTY;
      deliver_in = '0;
      count_in = count_ff;
      peak_in = peak_ff;
      req_gen_in = req_gen_ff;
      app_gen_in = app_gen_ff;
      panic_time_in = panic_time_ff;
      drops_in = drops_ff;
      recovery_in = recovery_ff;
      rec_pend_in = recovery_ff;
      case (act_ff)
         ACT_ENQUEUE: begin
            if (cmd_ff.cmd_type == T_PANIC) begin
               panic_time_in = cmd_ff.timestamp;
               req_gen_in = req_gen_ff + 32'd1;
               status_in = ST_PANIC_RAISED;
            end else if (found_ff) begin
               status_in = ST_COALESCED;
            end else if (no_room) begin
               if (drops_ff != '1) drops_in = drops_ff + 32'd1;
               if (rel) begin
                  panic_time_in = cmd_ff.timestamp;
                  req_gen_in = req_gen_ff + 32'd1;
                  recovery_in = 1'b1;
                  rec_pend_in = 1'b1;
                  status_in = ST_DROP_PANIC;
               end else begin
                  status_in = ST_DROPPED;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               if (count_in > peak_ff) peak_in = count_in;
               status_in = ST_QUEUED;
            end
         end
         ACT_TAKE: begin
            if (app_gen_ff != req_gen_ff) begin
               deliver_in.cmd_type = T_PANIC;
               deliver_in.generation = req_gen_ff;
               deliver_in.timestamp = panic_time_ff;
               app_gen_in = req_gen_ff;
               status_in = ST_PANIC_DELIV;
            end else if (count_ff != '0) begin
               deliver_in = head;
               count_in = count_ff - CNT_W'(1);
               if (is_musical(head.cmd_type) && head.generation != app_gen_ff) begin
                  if (drops_ff != '1) drops_in = drops_ff + 32'd1;
                  status_in = ST_STALE;
               end else begin
                  status_in = ST_DELIVERED;
               end
            end
         end
         ACT_ACK: begin
            recovery_in = 1'b0;
            status_in = ST_ACKED;
         end
         default: status_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         peak_ff <= '0;
         req_gen_ff <= '0;
         app_gen_ff <= '0;
         panic_time_ff <= '0;
         drops_ff <= '0;
         recovery_ff <= 1'b0;
         reserve_ff <= 5'd4;
         rsp_valid <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_EXEC);
         if (psel && penable && pwrite && paddr == 2'd0) reserve_ff <= pwdata[4:0];
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff <= req_action;
                  cmd_ff <= '{cmd_type: req_cmd_type, channel: req_channel, id: req_id,
                              first_value: req_first_value, payload: req_payload,
                              generation: '0, timestamp: req_timestamp};
                  found_ff <= 1'b0;
                  scan_ff <= count_ff;
                  if (req_action == ACT_ENQUEUE && coalescible_kind(req_cmd_type))
                     state_ff <= S_SCAN;
                  else
                     state_ff <= S_EXEC;
               end
            end
            S_SCAN: begin
               if (scan_ff == '0) begin
                  state_ff <= S_EXEC;
               end else if (hits[scan_idx - 1'b1]) begin
                  found_ff <= 1'b1;
                  found_idx_ff <= scan_idx - 1'b1;
                  state_ff <= S_EXEC;
               end else begin
                  scan_ff <= scan_ff - 1'b1;
               end
            end
            S_EXEC: begin
               state_ff <= S_IDLE;
               count_ff <= count_in;
               peak_ff <= peak_in;
               req_gen_ff <= req_gen_in;
               app_gen_ff <= app_gen_in;
               panic_time_ff <= panic_time_in;
               drops_ff <= drops_in;
               recovery_ff <= recovery_in;
               rsp_status <= status_in;
               rsp_out_type <= deliver_in.cmd_type;
               rsp_out_channel <= deliver_in.channel;
               rsp_out_id <= deliver_in.id;
               rsp_out_first_value <= deliver_in.first_value;
               rsp_out_payload <= deliver_in.payload;
               rsp_out_generation <= deliver_in.generation;
               rsp_out_timestamp <= deliver_in.timestamp;
               rsp_queue_count <= 6'(count_in);
               rsp_recovery_pending <= rec_pend_in;
               rsp_high_water <= 6'(peak_in);
               rsp_dropped_total <= drops_in;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {27'd0, reserve_ff} : 32'd0;

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");
   assert property (@(posedge clock) disable iff (reset) peak_ff >= count_ff)
      else $error("high water below occupancy");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> $past(state_ff == S_EXEC))
      else $error("result without execute step");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_IDLE && start) |=> busy)
      else $error("accepted command did not raise busy");
endmodule
`default_nettype wire
